### hdl/tcd_pkg.sv
// shared types, register codes and checksum helpers for the tile change detector
`default_nettype none

package tcd_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_CHECKSUM_MODE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIGNIFICANT_BITS = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILE_WIDTH       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILE_HEIGHT      = 3'd5;

   localparam logic [1:0] MODE_TRIVIAL = 2'd0;
   localparam logic [1:0] MODE_CRC     = 2'd1;
   localparam logic [1:0] MODE_ADLER   = 2'd2;

   localparam logic [31:0] CRC_POLY   = 32'hedb8_8320;
   localparam logic [16:0] ADLER_MOD  = 17'd65521;
   localparam logic [18:0] ADLER_MOD_2 = 19'd131042;
   localparam logic [18:0] ADLER_MOD_3 = 19'd196563;
   localparam logic [18:0] ADLER_MOD_4 = 19'd262084;
   localparam logic [7:0]  ALPHA_BYTE = 8'hff;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [5:0]  tile_column;
      logic [5:0]  tile_row;
      logic        changed;
      logic [63:0] signature;
      logic [31:0] updated_total;
      logic [31:0] unchanged_total;
      logic        map_overflow;
      logic        frame_done;
   } result_type;

   // per-pixel tile position flags handed from the raster tracker
   typedef struct packed {
      logic first;
      logic last;
      logic frame_done;
      logic overflow;
   } tile_flags_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
      logic [31:0] c;
      c = c_in ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

   // input is below twice the modulus, one conditional subtract is enough
   function automatic logic [16:0] adler_fold(input logic [16:0] x);
      return (x >= ADLER_MOD) ? x - ADLER_MOD : x;
   endfunction

   // adler-32 over the four bytes of one pixel; each A sum comes straight from a
   // prefix byte sum, and B is reduced once from its five terms
   function automatic logic [31:0] adler_pixel(input logic [31:0] s, input logic [7:0] r,
                                               input logic [7:0] g, input logic [7:0] b,
                                               input logic [7:0] a);
      logic [9:0]  p1, p2, p3, p4;
      logic [16:0] s1, s2, s3, s4;
      logic [18:0] tot, bsum;
      p1 = {2'd0, r};
      p2 = {2'd0, r} + {2'd0, g};
      p3 = {2'd0, r} + {2'd0, g} + {2'd0, b};
      p4 = {2'd0, r} + {2'd0, g} + {2'd0, b} + {2'd0, a};
      s1 = adler_fold({1'b0, s[15:0]} + {7'd0, p1});
      s2 = adler_fold({1'b0, s[15:0]} + {7'd0, p2});
      s3 = adler_fold({1'b0, s[15:0]} + {7'd0, p3});
      s4 = adler_fold({1'b0, s[15:0]} + {7'd0, p4});
      tot = {3'd0, s[31:16]} + {2'd0, s1} + {2'd0, s2} + {2'd0, s3} + {2'd0, s4};
      priority if (tot >= ADLER_MOD_4) begin
         bsum = tot - ADLER_MOD_4;
      end else if (tot >= ADLER_MOD_3) begin
         bsum = tot - ADLER_MOD_3;
      end else if (tot >= ADLER_MOD_2) begin
         bsum = tot - ADLER_MOD_2;
      end else if (tot >= 19'(ADLER_MOD)) begin
         bsum = tot - 19'(ADLER_MOD);
      end else begin
         bsum = tot;
      end
      return {bsum[15:0], s4[15:0]};
   endfunction

endpackage

`default_nettype wire

### hdl/tcd_ram.sv
// generic single write port memory with registered read
`default_nettype none

module tcd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### hdl/tcd_raster.sv
// raster position tracker: pixel and tile counters without division
`default_nettype none

module tcd_raster import tcd_pkg::*; #(
   parameter int MAX_TILE_COLUMNS = 64,
   parameter int MAX_TILE_ROWS    = 64,
   parameter int MAX_FRAME_SIDE   = 4096,
   parameter int MAX_TILE_SIDE    = 256,
   localparam int W_POS  = $clog2(MAX_FRAME_SIDE),
   localparam int W_FS   = $clog2(MAX_FRAME_SIDE + 1),
   localparam int W_X    = MAX_TILE_SIDE > 1 ? $clog2(MAX_TILE_SIDE) : 1,
   localparam int W_TS   = $clog2(MAX_TILE_SIDE + 1),
   localparam int W_SLOT = MAX_TILE_COLUMNS > 1 ? $clog2(MAX_TILE_COLUMNS) : 1,
   localparam int DEPTH  = MAX_TILE_COLUMNS * MAX_TILE_ROWS,
   localparam int W_TIDX = DEPTH > 1 ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              restart,
   input  wire logic              advance,
   input  wire logic [W_FS-1:0]   frame_w,
   input  wire logic [W_FS-1:0]   frame_h,
   input  wire logic [W_TS-1:0]   tile_w,
   input  wire logic [W_TS-1:0]   tile_h,
   output      tile_flags_type    flags,
   output      logic [W_POS-1:0]  tile_col,
   output      logic [W_POS-1:0]  tile_row,
   output      logic [W_SLOT-1:0] slot,
   output      logic [W_TIDX-1:0] tile_index
);

   logic [W_POS-1:0]  col_pos_ff, col_pos_in, row_pos_ff, row_pos_in;
   logic [W_X-1:0]    x_ff, x_in, y_ff, y_in;
   logic [W_POS-1:0]  tcol_ff, tcol_in, trow_ff, trow_in;
   logic [W_SLOT-1:0] slot_ff, slot_in;
   logic [W_TIDX-1:0] base_ff, base_in;
   logic x_end, y_end, c_end, r_end;

   assign x_end = (W_TS'(x_ff) + 1'b1) == tile_w;
   assign y_end = (W_TS'(y_ff) + 1'b1) == tile_h;
   assign c_end = (W_FS'(col_pos_ff) + 1'b1) == frame_w;
   assign r_end = (W_FS'(row_pos_ff) + 1'b1) == frame_h;

   always_comb begin
      flags.first      = (x_ff == '0) && (y_ff == '0);
      flags.last       = (x_end || c_end) && (y_end || r_end);
      flags.frame_done = c_end && r_end;
      flags.overflow   = (32'(tcol_ff) >= MAX_TILE_COLUMNS) ||
                         (32'(trow_ff) >= MAX_TILE_ROWS);
      tile_col   = tcol_ff;
      tile_row   = trow_ff;
      slot       = slot_ff;
      tile_index = base_ff + W_TIDX'(tcol_ff);
   end

   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      tcol_in    = tcol_ff;
      trow_in    = trow_ff;
      slot_in    = slot_ff;
      base_in    = base_ff;
      if (restart) begin
         col_pos_in = '0;
         row_pos_in = '0;
         x_in       = '0;
         y_in       = '0;
         tcol_in    = '0;
         trow_in    = '0;
         slot_in    = '0;
         base_in    = '0;
      end else if (advance) begin
         if (c_end) begin
            col_pos_in = '0;
            x_in       = '0;
            tcol_in    = '0;
            slot_in    = '0;
            if (r_end) begin
               row_pos_in = '0;
               y_in       = '0;
               trow_in    = '0;
               base_in    = '0;
            end else begin
               row_pos_in = row_pos_ff + 1'b1;
               if (y_end) begin
                  y_in    = '0;
                  trow_in = trow_ff + 1'b1;
                  // base only matters while the row is inside the map
                  if (32'(trow_ff) + 1 < MAX_TILE_ROWS) begin
                     base_in = base_ff + W_TIDX'(MAX_TILE_COLUMNS);
                  end
               end else begin
                  y_in = y_ff + 1'b1;
               end
            end
         end else begin
            col_pos_in = col_pos_ff + 1'b1;
            if (x_end) begin
               x_in    = '0;
               tcol_in = tcol_ff + 1'b1;
               slot_in = (slot_ff == W_SLOT'(MAX_TILE_COLUMNS - 1)) ? '0 : slot_ff + 1'b1;
            end else begin
               x_in = x_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
         x_ff       <= '0;
         y_ff       <= '0;
         tcol_ff    <= '0;
         trow_ff    <= '0;
         slot_ff    <= '0;
         base_ff    <= '0;
      end else begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
         x_ff       <= x_in;
         y_ff       <= y_in;
         tcol_ff    <= tcol_in;
         trow_ff    <= trow_in;
         slot_ff    <= slot_in;
         base_ff    <= base_in;
      end
   end

endmodule

`default_nettype wire

### hdl/tile_change_detector.sv
// top level of the tile change detector
`default_nettype none

// Tile change detector. Pixels arrive in raster order, one request per clock while
// req_stall is low, and are cut into tiles (partial at the right and bottom edges). Each
// tile gets a signature (CRC-32, Adler-32 from zero, or first/last packed pixel) which is
// compared with the signature stored for that tile; at the tile's last pixel one result
// reports the tile position, whether it changed and the running counts. The block sustains
// one pixel per clock while neither a stalled result nor the clearing pass holds it; a
// tile's result passes from that pixel through the running signature read-modify-write,
// the stored signature read and compare, and the output register. A stalled result holds
// the whole pipe and stalls the request side in the same cycle. The running signature of
// each tile column lives in a small memory and the per-tile signatures in a second memory
// of MAX_TILE_COLUMNS * MAX_TILE_ROWS entries; back-to-back hits on the same entry are
// served by forwarding registers. After reset a clearing pass zeroes the tile memory, one
// entry per cycle, during which no pixel is taken. Configuration writes restart the frame
// and are legal only while the block is idle.

module tile_change_detector import tcd_pkg::*; #(
   parameter int MAX_TILE_COLUMNS = 64,
   parameter int MAX_TILE_ROWS    = 64,
   parameter int MAX_FRAME_SIDE   = 4096,
   parameter int MAX_TILE_SIDE    = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // pixel requests
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire pixel_type              req_data,
   // tile results
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      result_type             rsp_data,
   // register writes
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int W_POS  = $clog2(MAX_FRAME_SIDE);
   localparam int W_FS   = $clog2(MAX_FRAME_SIDE + 1);
   localparam int W_TS   = $clog2(MAX_TILE_SIDE + 1);
   localparam int W_SLOT = MAX_TILE_COLUMNS > 1 ? $clog2(MAX_TILE_COLUMNS) : 1;
   localparam int DEPTH  = MAX_TILE_COLUMNS * MAX_TILE_ROWS;
   localparam int W_TIDX = DEPTH > 1 ? $clog2(DEPTH) : 1;

   // configuration registers
   logic [1:0]  mode_ff;
   logic [3:0]  sig_bits_ff;
   logic [12:0] frame_width_ff, frame_height_ff;
   logic [8:0]  tile_width_ff, tile_height_ff;
   logic        csr_write, restart;

   // clamped geometry and channel mask
   logic [W_FS-1:0] frame_w, frame_h;
   logic [W_TS-1:0] tile_w, tile_h;
   logic [3:0]      keep_bits;
   logic [7:0]      chan_mask;

   // handshake and pipeline control
   logic advance, accept;
   logic clear_ff;
   logic [W_TIDX-1:0] clear_addr_ff;

   // tracker outputs
   tile_flags_type     flags;
   logic [W_POS-1:0]   tile_col, tile_row;
   logic [W_SLOT-1:0]  slot;
   logic [W_TIDX-1:0]  tile_index;

   // stage 1: running signature read-modify-write
   logic               p1_valid_ff;
   tile_flags_type     p1_flags_ff;
   logic [W_POS-1:0]   p1_col_ff, p1_row_ff;
   logic [W_SLOT-1:0]  p1_slot_ff;
   logic [W_TIDX-1:0]  p1_index_ff;
   logic [7:0]         p1_r_ff, p1_g_ff, p1_b_ff, p1_a_ff;
   logic [63:0]        run_rd, run_prev, run_next, p1_sig;
   logic [31:0]        packed_px, acc;
   logic               rfwd_valid_ff;
   logic [W_SLOT-1:0]  rfwd_slot_ff;
   logic [63:0]        rfwd_value_ff;
   logic               run_wr;

   // stage 2: stored signature compare
   logic               p2_valid_ff;
   logic [5:0]         p2_col_ff, p2_row_ff;
   logic [63:0]        p2_sig_ff;
   logic               p2_ovf_ff, p2_done_ff;
   logic [W_TIDX-1:0]  p2_index_ff;
   logic [63:0]        tile_rd, stored;
   logic               changed;
   logic               tfwd_valid_ff;
   logic [W_TIDX-1:0]  tfwd_index_ff;
   logic [63:0]        tfwd_value_ff;
   logic               tile_wr_en;
   logic [W_TIDX-1:0]  tile_wr_addr;
   logic [63:0]        tile_wr_data;
   logic [31:0]        updated_count_ff, unchanged_count_ff;
   logic [31:0]        updated_next, unchanged_next;

   // output register
   logic               rsp_valid_ff;
   result_type         rsp_data_ff;

   // ---------------------------------------------------------------- registers
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   // writes beyond the register list are dropped and do not restart
   assign restart   = csr_write && (csr_index <= CSR_TILE_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_CRC;
         sig_bits_ff     <= 4'd8;
         frame_width_ff  <= 13'd640;
         frame_height_ff <= 13'd480;
         tile_width_ff   <= 9'd16;
         tile_height_ff  <= 9'd16;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_CHECKSUM_MODE:    mode_ff         <= csr_data[1:0];
            CSR_SIGNIFICANT_BITS: sig_bits_ff     <= csr_data[3:0];
            CSR_FRAME_WIDTH:      frame_width_ff  <= csr_data;
            CSR_FRAME_HEIGHT:     frame_height_ff <= csr_data;
            CSR_TILE_WIDTH:       tile_width_ff   <= csr_data[8:0];
            CSR_TILE_HEIGHT:      tile_height_ff  <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   // clamp sides into range, zero acts as one
   always_comb begin
      frame_w = (frame_width_ff == '0) ? W_FS'(1) :
                (32'(frame_width_ff) > MAX_FRAME_SIDE) ? W_FS'(MAX_FRAME_SIDE) :
                W_FS'(frame_width_ff);
      frame_h = (frame_height_ff == '0) ? W_FS'(1) :
                (32'(frame_height_ff) > MAX_FRAME_SIDE) ? W_FS'(MAX_FRAME_SIDE) :
                W_FS'(frame_height_ff);
      tile_w  = (tile_width_ff == '0) ? W_TS'(1) :
                (32'(tile_width_ff) > MAX_TILE_SIDE) ? W_TS'(MAX_TILE_SIDE) :
                W_TS'(tile_width_ff);
      tile_h  = (tile_height_ff == '0) ? W_TS'(1) :
                (32'(tile_height_ff) > MAX_TILE_SIDE) ? W_TS'(MAX_TILE_SIDE) :
                W_TS'(tile_height_ff);
      keep_bits = (sig_bits_ff > 4'd8) ? 4'd8 : sig_bits_ff;
      chan_mask = 8'(16'h00ff << (4'd8 - keep_bits));
   end

   // ---------------------------------------------------------------- handshake
   // the whole pipeline moves unless a finished result is held by the consumer
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance || clear_ff;
   assign accept    = req_valid && !req_stall;

   // clearing pass over the stored signatures after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_ff) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
         if (clear_addr_ff == W_TIDX'(DEPTH - 1)) begin
            clear_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- stage 0
   tcd_raster #(
      .MAX_TILE_COLUMNS (MAX_TILE_COLUMNS),
      .MAX_TILE_ROWS    (MAX_TILE_ROWS),
      .MAX_FRAME_SIDE   (MAX_FRAME_SIDE),
      .MAX_TILE_SIDE    (MAX_TILE_SIDE)
   ) u_raster (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .advance    (accept),
      .frame_w    (frame_w),
      .frame_h    (frame_h),
      .tile_w     (tile_w),
      .tile_h     (tile_h),
      .flags      (flags),
      .tile_col   (tile_col),
      .tile_row   (tile_row),
      .slot       (slot),
      .tile_index (tile_index)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_flags_ff <= flags;
         p1_col_ff   <= tile_col;
         p1_row_ff   <= tile_row;
         p1_slot_ff  <= slot;
         p1_index_ff <= tile_index;
         p1_r_ff     <= req_data.red & chan_mask;
         p1_g_ff     <= req_data.green & chan_mask;
         p1_b_ff     <= req_data.blue & chan_mask;
         p1_a_ff     <= ALPHA_BYTE & chan_mask;
      end
   end

   // running signature per tile column
   tcd_ram #(
      .WIDTH (64),
      .DEPTH (MAX_TILE_COLUMNS)
   ) u_run_ram (
      .clock   (clock),
      .wr_en   (run_wr),
      .wr_addr (p1_slot_ff),
      .wr_data (run_next),
      .rd_en   (advance),
      .rd_addr (slot),
      .rd_data (run_rd)
   );

   // ---------------------------------------------------------------- stage 1
   always_comb begin
      // the last update to the same slot may not have reached the read yet
      run_prev  = (rfwd_valid_ff && rfwd_slot_ff == p1_slot_ff) ? rfwd_value_ff : run_rd;
      packed_px = {p1_a_ff, p1_b_ff, p1_g_ff, p1_r_ff};
      acc       = '0;
      run_next  = '0;
      p1_sig    = '0;
      unique case (mode_ff)
         MODE_TRIVIAL: begin
            run_next = p1_flags_ff.first ? {packed_px, packed_px} : {run_prev[63:32], packed_px};
            p1_sig   = run_next;
         end
         MODE_ADLER: begin
            acc      = adler_pixel(p1_flags_ff.first ? 32'd0 : run_prev[31:0],
                                   p1_r_ff, p1_g_ff, p1_b_ff, p1_a_ff);
            run_next = {32'd0, acc};
            p1_sig   = run_next;
         end
         default: begin
            // crc-32; the unused mode code behaves the same
            acc      = p1_flags_ff.first ? 32'hffff_ffff : run_prev[31:0];
            acc      = crc_byte(acc, p1_r_ff);
            acc      = crc_byte(acc, p1_g_ff);
            acc      = crc_byte(acc, p1_b_ff);
            acc      = crc_byte(acc, p1_a_ff);
            run_next = {32'd0, acc};
            p1_sig   = {32'd0, ~acc};
         end
      endcase
   end

   assign run_wr = advance && p1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rfwd_valid_ff <= 1'b0;
         p2_valid_ff   <= 1'b0;
      end else if (advance) begin
         if (p1_valid_ff) begin
            rfwd_valid_ff <= 1'b1;
         end
         p2_valid_ff <= p1_valid_ff && p1_flags_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (run_wr) begin
         rfwd_slot_ff  <= p1_slot_ff;
         rfwd_value_ff <= run_next;
      end
      if (advance) begin
         p2_col_ff   <= 6'(p1_col_ff);
         p2_row_ff   <= 6'(p1_row_ff);
         p2_sig_ff   <= p1_sig;
         p2_ovf_ff   <= p1_flags_ff.overflow;
         p2_done_ff  <= p1_flags_ff.frame_done;
         p2_index_ff <= p1_index_ff;
      end
   end

   // stored signature per tile
   tcd_ram #(
      .WIDTH (64),
      .DEPTH (DEPTH)
   ) u_tile_ram (
      .clock   (clock),
      .wr_en   (tile_wr_en),
      .wr_addr (tile_wr_addr),
      .wr_data (tile_wr_data),
      .rd_en   (advance),
      .rd_addr (p1_index_ff),
      .rd_data (tile_rd)
   );

   // ---------------------------------------------------------------- stage 2
   always_comb begin
      stored  = (tfwd_valid_ff && tfwd_index_ff == p2_index_ff) ? tfwd_value_ff : tile_rd;
      changed = p2_ovf_ff || (stored != p2_sig_ff);
      updated_next   = updated_count_ff + (changed ? 32'd1 : 32'd0);
      unchanged_next = unchanged_count_ff + (changed ? 32'd0 : 32'd1);
      if (clear_ff) begin
         tile_wr_en   = 1'b1;
         tile_wr_addr = clear_addr_ff;
         tile_wr_data = '0;
      end else begin
         tile_wr_en   = advance && p2_valid_ff && !p2_ovf_ff && changed;
         tile_wr_addr = p2_index_ff;
         tile_wr_data = p2_sig_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tfwd_valid_ff      <= 1'b0;
         updated_count_ff   <= '0;
         unchanged_count_ff <= '0;
         rsp_valid_ff       <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= p2_valid_ff;
         if (p2_valid_ff) begin
            updated_count_ff   <= updated_next;
            unchanged_count_ff <= unchanged_next;
            if (!p2_ovf_ff) begin
               tfwd_valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && p2_valid_ff && !p2_ovf_ff) begin
         tfwd_index_ff <= p2_index_ff;
         tfwd_value_ff <= p2_sig_ff;
      end
      if (advance) begin
         rsp_data_ff.tile_column     <= p2_col_ff;
         rsp_data_ff.tile_row        <= p2_row_ff;
         rsp_data_ff.changed         <= changed;
         rsp_data_ff.signature       <= p2_sig_ff;
         rsp_data_ff.updated_total   <= updated_next;
         rsp_data_ff.unchanged_total <= unchanged_next;
         rsp_data_ff.map_overflow    <= p2_ovf_ff;
         rsp_data_ff.frame_done      <= p2_done_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   // no pixel enters while the tile memory is being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !accept)
      else $error("pixel taken during clearing pass");

   // a tile outside the map is always reported as changed
   a_overflow_changed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.map_overflow |-> rsp_data.changed)
      else $error("overflow tile reported unchanged");

   // every completed tile bumps exactly one of the two counts
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      advance && p2_valid_ff |=>
         (updated_count_ff + unchanged_count_ff) ==
         ($past(updated_count_ff) + $past(unchanged_count_ff) + 32'd1))
      else $error("tile counts did not advance by one");

endmodule

`default_nettype wire

### test/tile_change_detector_test.sv
// testbench for the tile change detector: scoreboard, pixel driver and result checker
`timescale 1ns / 100ps

module tile_change_detector_test;
   import tcd_pkg::*;

   // tile map size and side limits of the block as instantiated
   localparam int TILE_COLUMNS = 64;
   localparam int TILE_ROWS    = 64;
   localparam int FRAME_SIDE   = 4096;
   localparam int TILE_SIDE    = 256;

   // tracks raster position, tile signatures and counts, holds the tile reports still due
   class tile_scoreboard;
      logic [1:0]  mode;
      logic [3:0]  sig_bits;
      logic [12:0] width_reg, height_reg;
      logic [8:0]  tile_w_reg, tile_h_reg;
      int unsigned col_pos, row_pos;
      logic [63:0] partial_sig [TILE_COLUMNS];
      logic [63:0] stored_sig [TILE_COLUMNS*TILE_ROWS];
      logic [31:0] changed_cnt, same_cnt;
      result_type  due_reports [$];
      int          errors;
      int          reports_seen, changed_seen, overflow_seen, frames_seen;

      function new();
         mode = MODE_CRC;
         sig_bits = 4'd8;
         width_reg = 13'd640;
         height_reg = 13'd480;
         tile_w_reg = 9'd16;
         tile_h_reg = 9'd16;
         col_pos = 0;
         row_pos = 0;
         foreach (partial_sig[i]) partial_sig[i] = '0;
         foreach (stored_sig[i]) stored_sig[i] = '0;
         changed_cnt = '0;
         same_cnt = '0;
         errors = 0;
         reports_seen = 0;
         changed_seen = 0;
         overflow_seen = 0;
         frames_seen = 0;
      endfunction

      function int unsigned clamp(int unsigned v, int unsigned hi);
         if (v < 1) return 1;
         if (v > hi) return hi;
         return v;
      endfunction

      function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
         logic [31:0] r;
         r = c ^ {24'd0, b};
         repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
         return r;
      endfunction

      function logic [31:0] adler_step(logic [31:0] s, logic [7:0] b);
         int unsigned lo, hi;
         lo = (s[15:0] + b) % 65521;
         hi = (s[31:16] + lo) % 65521;
         return {hi[15:0], lo[15:0]};
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_CHECKSUM_MODE:    mode = val[1:0];
            CSR_SIGNIFICANT_BITS: sig_bits = val[3:0];
            CSR_FRAME_WIDTH:      width_reg = val;
            CSR_FRAME_HEIGHT:     height_reg = val;
            CSR_TILE_WIDTH:       tile_w_reg = val[8:0];
            CSR_TILE_HEIGHT:      tile_h_reg = val[8:0];
            default:              return;
         endcase
         col_pos = 0;
         row_pos = 0;
      endfunction

      // one accepted pixel request; queues a tile report when it closes a tile
      function void note_pixel(pixel_type px);
         int unsigned fw, fh, tw, th, bits, mask, col, row, xin, yin, cw, ch, slot;
         logic [31:0] packed_px, s;
         logic [7:0]  r, g, b, a;
         logic [63:0] run, sig;
         logic        closes, last_of_frame, overflow, changed;
         result_type  rep;
         fw = clamp(width_reg, FRAME_SIDE);
         fh = clamp(height_reg, FRAME_SIDE);
         tw = clamp(tile_w_reg, TILE_SIDE);
         th = clamp(tile_h_reg, TILE_SIDE);
         bits = (sig_bits > 8) ? 8 : sig_bits;
         mask = (32'hff << (8 - bits)) & 32'hff;
         if (col_pos >= fw || row_pos >= fh) begin
            col_pos = 0;
            row_pos = 0;
         end
         col = col_pos / tw;
         xin = col_pos % tw;
         row = row_pos / th;
         yin = row_pos % th;
         cw = fw - col * tw;
         if (cw > tw) cw = tw;
         ch = fh - row * th;
         if (ch > th) ch = th;
         r = px.red & mask[7:0];
         g = px.green & mask[7:0];
         b = px.blue & mask[7:0];
         a = 8'hff & mask[7:0];
         packed_px = {a, b, g, r};
         slot = col % TILE_COLUMNS;
         run = partial_sig[slot];
         if (xin == 0 && yin == 0) begin
            if (mode == MODE_TRIVIAL) run = {packed_px, 32'd0};
            else if (mode == MODE_ADLER) run = '0;
            else run = 64'hffff_ffff;
         end
         if (mode == MODE_TRIVIAL) begin
            run[31:0] = packed_px;
         end else if (mode == MODE_ADLER) begin
            s = adler_step(adler_step(adler_step(adler_step(run[31:0], r), g), b), a);
            run = {32'd0, s};
         end else begin
            s = crc_step(crc_step(crc_step(crc_step(run[31:0], r), g), b), a);
            run = {32'd0, s};
         end
         partial_sig[slot] = run;
         closes = (xin == cw - 1) && (yin == ch - 1);
         last_of_frame = (col_pos + 1 == fw) && (row_pos + 1 == fh);
         col_pos++;
         if (col_pos >= fw) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= fh) row_pos = 0;
         end
         if (!closes) return;
         if (mode == MODE_TRIVIAL) sig = run;
         else if (mode == MODE_ADLER) sig = {32'd0, run[31:0]};
         else sig = {32'd0, ~run[31:0]};
         overflow = (col >= TILE_COLUMNS) || (row >= TILE_ROWS);
         if (overflow) begin
            changed = 1'b1;
         end else begin
            changed = stored_sig[row*TILE_COLUMNS + col] != sig;
            if (changed) stored_sig[row*TILE_COLUMNS + col] = sig;
         end
         if (changed) changed_cnt++;
         else same_cnt++;
         rep.tile_column = col[5:0];
         rep.tile_row = row[5:0];
         rep.changed = changed;
         rep.signature = sig;
         rep.updated_total = changed_cnt;
         rep.unchanged_total = same_cnt;
         rep.map_overflow = overflow;
         rep.frame_done = last_of_frame;
         due_reports = {due_reports, rep};
      endfunction

      // one accepted tile report against the oldest one due
      function void check_report(result_type got);
         result_type want;
         if (due_reports.size() == 0) begin
            $error("tile report with none due: %p", got);
            errors++;
            return;
         end
         want = due_reports.pop_front();
         reports_seen++;
         if (got.changed) changed_seen++;
         if (got.map_overflow) overflow_seen++;
         if (got.frame_done) frames_seen++;
         if (got.tile_column !== want.tile_column) begin
            $error("tile_column expected %0d got %0d", want.tile_column, got.tile_column);
            errors++;
         end
         if (got.tile_row !== want.tile_row) begin
            $error("tile_row expected %0d got %0d", want.tile_row, got.tile_row);
            errors++;
         end
         if (got.changed !== want.changed) begin
            $error("changed expected %0d got %0d", want.changed, got.changed);
            errors++;
         end
         if (got.signature !== want.signature) begin
            $error("signature expected %h got %h", want.signature, got.signature);
            errors++;
         end
         if (got.updated_total !== want.updated_total) begin
            $error("updated_total expected %0d got %0d", want.updated_total,
                   got.updated_total);
            errors++;
         end
         if (got.unchanged_total !== want.unchanged_total) begin
            $error("unchanged_total expected %0d got %0d", want.unchanged_total,
                   got.unchanged_total);
            errors++;
         end
         if (got.map_overflow !== want.map_overflow) begin
            $error("map_overflow expected %0d got %0d", want.map_overflow, got.map_overflow);
            errors++;
         end
         if (got.frame_done !== want.frame_done) begin
            $error("frame_done expected %0d got %0d", want.frame_done, got.frame_done);
            errors++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   pixel_type              req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   result_type             rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   tile_scoreboard board;
   int          idle_pct;      // chance in a hundred that the sender skips a cycle
   int          stall_pct;     // chance in a hundred that the receiver stalls a cycle
   int          hold_off;      // cycles of forced receiver stall still to go
   int unsigned pixel_count;   // raster index used to build repeating frame content
   int          sent;

   tile_change_detector #(
      .MAX_TILE_COLUMNS(TILE_COLUMNS),
      .MAX_TILE_ROWS   (TILE_ROWS),
      .MAX_FRAME_SIDE  (FRAME_SIDE),
      .MAX_TILE_SIDE   (TILE_SIDE)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // safety net well beyond the slowest legal run, clearing pass included
   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

   // receiver side: random stalls, or a long forced hold-off when asked
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp_stall = 1'b1;
            hold_off--;
         end else begin
            rsp_stall = ($urandom_range(99) < stall_pct);
         end
      end
   end

   // result monitor, sampled on the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_report(rsp_data);
   end

   // one pixel request, held until the block takes it
   task automatic send_pixel(pixel_type px);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = px;
      do @(posedge clock); while (req_stall);
      board.note_pixel(px);
      sent++;
      @(negedge clock);
   endtask

   // register write, only once every tile report due has come and the pipe has drained
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      req_valid = 1'b0;
      while (board.due_reports.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_geometry(logic [1:0] mode, int bits, int fw, int fh, int tw, int th);
      write_csr(CSR_CHECKSUM_MODE, CSR_DATA_W'(mode));
      write_csr(CSR_SIGNIFICANT_BITS, CSR_DATA_W'(bits));
      write_csr(CSR_FRAME_WIDTH, CSR_DATA_W'(fw));
      write_csr(CSR_FRAME_HEIGHT, CSR_DATA_W'(fh));
      write_csr(CSR_TILE_WIDTH, CSR_DATA_W'(tw));
      write_csr(CSR_TILE_HEIGHT, CSR_DATA_W'(th));
      pixel_count = 0;
   endtask

   // mostly a repeating pattern so later frames hit unchanged tiles, with random edits
   function automatic pixel_type frame_pixel(int unsigned idx);
      pixel_type px;
      if ($urandom_range(19) == 0) begin
         px = 24'($urandom);
      end else begin
         px.red = 8'(idx * 37);
         px.green = 8'(idx * 11 + 3);
         px.blue = 8'(idx * 5 + 200);
      end
      return px;
   endfunction

   task automatic run_phase(logic [1:0] mode, int bits, int fw, int fh, int tw, int th,
                            int count, int idling);
      set_geometry(mode, bits, fw, fh, tw, th);
      case (idling % 4)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 68; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 68; end
         default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      repeat (count) begin
         send_pixel(frame_pixel(pixel_count));
         pixel_count++;
      end
      req_valid = 1'b0;
   endtask

   initial begin
      pixel_type px;
      int        wait_cycles;
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_CHECKSUM_MODE;
      csr_data = '0;
      idle_pct = 0;
      stall_pct = 0;
      hold_off = 0;
      pixel_count = 0;
      sent = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // a few pixels at the reset geometry: no tile closes yet
      repeat (4) send_pixel(24'($urandom));

      // directed: each checksum mode, extreme channel values, masking extremes
      set_geometry(MODE_TRIVIAL, 8, 3, 2, 2, 1);
      px = '0;         send_pixel(px);
      px = '1;         send_pixel(px);
      px = 24'h80017f; send_pixel(px);
      px = 24'h7ffe01; send_pixel(px);
      px = '1;         send_pixel(px);
      px = '0;         send_pixel(px);
      write_csr(CSR_CHECKSUM_MODE, CSR_DATA_W'(MODE_CRC));
      write_csr(CSR_SIGNIFICANT_BITS, CSR_DATA_W'(0));     // no bits kept
      repeat (3) send_pixel(24'($urandom));
      write_csr(CSR_CHECKSUM_MODE, CSR_DATA_W'(MODE_ADLER));
      write_csr(CSR_SIGNIFICANT_BITS, CSR_DATA_W'(15));    // acts as eight bits
      px = '1;         send_pixel(px);
      px = '1;         send_pixel(px);
      px = '0;         send_pixel(px);
      write_csr(CSR_CHECKSUM_MODE, CSR_DATA_W'(3));        // unused mode code, acts as crc
      write_csr(CSR_SIGNIFICANT_BITS, CSR_DATA_W'(1));
      repeat (3) send_pixel(24'($urandom));
      write_csr(3'd7, 13'h1fff);              // no such register: ignored, no restart
      repeat (3) send_pixel(24'($urandom));

      // random phases through several geometries and idling patterns
      run_phase(MODE_CRC,     8,  5,    4,  2,   3,   80,  0);
      run_phase(MODE_ADLER,   8,  7,    3,  7,   1,   80,  1);
      // long receiver hold-off while the sender keeps offering: block fills and stalls
      set_geometry(MODE_TRIVIAL, 3, 6, 6, 4, 4);
      idle_pct = 0;
      stall_pct = 0;
      hold_off = 400;
      repeat (100) begin
         send_pixel(frame_pixel(pixel_count));
         pixel_count++;
      end
      req_valid = 1'b0;
      run_phase(2'd3,         15, 1,    1,  1,   1,   60,  2);
      run_phase(MODE_CRC,     0,  70,   2,  1,   1,   140, 3);  // columns past the map
      run_phase(MODE_ADLER,   4,  2,    68, 1,   1,   140, 0);  // rows past the map
      run_phase(MODE_TRIVIAL, 6,  1,    70, 0,   511, 80,  1);  // tile sides clamped
      run_phase(MODE_CRC,     8,  8191, 0,  511, 1,   270, 2);  // widest frame, clamped
      run_phase(MODE_ADLER,   8,  4096, 1,  256, 256, 260, 3);
      run_phase(MODE_CRC,     2,  5,    4,  2,   3,   60,  3);

      // drain, then let the pipe settle
      wait_cycles = 0;
      while (board.due_reports.size() != 0 && wait_cycles < 100000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (10) @(negedge clock);

      $display("covered %0d pixel requests and %0d tile reports (%0d changed)",
               sent, board.reports_seen, board.changed_seen);
      $display("map overflow reports %0d, frame ends %0d", board.overflow_seen,
               board.frames_seen);
      if (board.errors == 0 && board.due_reports.size() == 0) begin
         $display("status: pass");
      end else begin
         if (board.due_reports.size() != 0)
            $error("%0d tile reports never arrived", board.due_reports.size());
         $display("status: fail");
      end
      $finish;
   end

endmodule
